// ----- design/pld_pkg.sv -----
`timescale 1ns / 1ps

package pld_pkg;

   localparam int PIX_W        = 16;
   localparam int OUT_W        = 32;
   localparam int KNEE_W       = 48;
   localparam int KNEE_IN_W    = 16;
   localparam int KNEE_OUT_LSB = 16;
   localparam int PROD_W       = PIX_W + OUT_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int KNEE_CNT_W   = 3;
   localparam int BITS_W       = 6;
   localparam int DIV_STAGES   = 8;
   localparam int DIV_BITS     = OUT_W / DIV_STAGES;

   localparam logic [KNEE_W-1:0] KNEE1_RESET = 48'h0000_FFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KNEE0       = 3'd0,
      REG_KNEE1       = 3'd1,
      REG_KNEE2       = 3'd2,
      REG_KNEE3       = 3'd3,
      REG_KNEE4       = 3'd4,
      REG_KNEE_COUNT  = 3'd5,
      REG_PEDESTAL    = 3'd6,
      REG_OUTPUT_BITS = 3'd7
   } csr_reg_type;

endpackage

// ----- design/piecewise_linear_decompander_core.sv -----
`timescale 1ns / 1ps
// Piecewise-linear decompander for a sensor pixel stream.
// req_* carries one companded pixel per beat; rsp_* returns one linear pixel
// per beat, with rsp_tuser set when the input lay past the last knee (the
// value is then zero). Items enter and leave in order, one result per input.
// An accepted req beat passes stages 1-3, the divider, stage 4 and the
// output register to reach rsp. Throughput: one beat per cycle unless the
// receiver stalls. The segment quotient uses an 8-stage restoring divider,
// 4 quotient bits per stage, after a 16x32 multiply; these set the depth.
// csr_* writes the knees, knee count, pedestal and output width. Write them
// only while no beat is in flight; there is no read-back.
// Reset (synchronous, active high) empties the pipeline and loads the default
// curve: knees at 0 and 65535, pedestal 0, 32-bit output.
// When the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated. A bubble does not collapse while stalled.
module piecewise_linear_decompander_core
   import pld_pkg::*;
#(
   parameter int NUM_KNEES = 5,
   parameter int IN_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [15:0] pixel_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,   // [31:0] pixel_out
   output logic [0:0]            rsp_tuser,   // [0] beyond_curve
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KIDX_W = (NUM_KNEES > 1) ? $clog2(NUM_KNEES) : 1;

   typedef struct packed {
      logic             valid;
      logic             beyond;
      logic             neg;
      logic [OUT_W-1:0] base;
      logic [PIX_W-1:0] den;
      logic [PIX_W-1:0] rem;
      logic [OUT_W-1:0] quo;
   } div_type;

   logic [KNEE_W-1:0]     knee_ff [NUM_KNEES];
   logic [KNEE_CNT_W-1:0] knee_count_ff;
   logic [OUT_W-1:0]      pedestal_ff;
   logic [BITS_W-1:0]     out_bits_ff;

   logic adv;

   logic [KNEE_IN_W-1:0]  kin  [NUM_KNEES];
   logic [OUT_W-1:0]      kout [NUM_KNEES];
   logic [PIX_W-1:0]      x_w;
   logic [KNEE_CNT_W-1:0] used_n;
   logic [KNEE_CNT_W-1:0] last_idx;
   logic [KNEE_IN_W-1:0]  last_in;
   logic [OUT_W-1:0]      last_kout;
   logic                  seg_found;
   logic [KNEE_IN_W-1:0]  seg_s;
   logic [KNEE_IN_W-1:0]  seg_e;
   logic [OUT_W-1:0]      seg_so;
   logic [OUT_W-1:0]      seg_eo;

   logic                  s1_valid_ff;
   logic                  s1_beyond_ff;
   logic                  s1_hit_ff;
   logic                  s1_found_ff;
   logic [IN_BITS-1:0]    s1_x_ff;
   logic [KNEE_IN_W-1:0]  s1_s_ff;
   logic [KNEE_IN_W-1:0]  s1_e_ff;
   logic [OUT_W-1:0]      s1_so_ff;
   logic [OUT_W-1:0]      s1_eo_ff;
   logic [OUT_W-1:0]      s1_lout_ff;

   logic                  s2_neg_in;
   logic [OUT_W-1:0]      s2_base_in;
   logic [PIX_W-1:0]      s2_dx_in;
   logic [PIX_W-1:0]      s2_d_in;
   logic [OUT_W-1:0]      s2_mag_in;

   logic                  s2_valid_ff;
   logic                  s2_beyond_ff;
   logic                  s2_neg_ff;
   logic [OUT_W-1:0]      s2_base_ff;
   logic [PIX_W-1:0]      s2_dx_ff;
   logic [PIX_W-1:0]      s2_d_ff;
   logic [OUT_W-1:0]      s2_mag_ff;

   logic                  s3_valid_ff;
   logic                  s3_beyond_ff;
   logic                  s3_neg_ff;
   logic [OUT_W-1:0]      s3_base_ff;
   logic [PIX_W-1:0]      s3_d_ff;
   logic [PROD_W-1:0]     s3_prod_ff;

   div_type               div_src [DIV_STAGES];
   div_type               dv_in   [DIV_STAGES];
   div_type               dv_ff   [DIV_STAGES];
   logic                  rem_ok;

   logic [OUT_W-1:0]      s4_curve_in;
   logic                  s4_valid_ff;
   logic                  s4_beyond_ff;
   logic [OUT_W-1:0]      s4_curve_ff;

   logic [BITS_W-1:0]     bits_eff;
   logic [OUT_W:0]        one_sh;
   logic [OUT_W-1:0]      clip_mask;
   logic [OUT_W-1:0]      ped_sub;
   logic [OUT_W-1:0]      rsp_tdata_in;

   logic                  rsp_tvalid_ff;
   logic [OUT_W-1:0]      rsp_tdata_ff;
   logic                  rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KNEES; k++) begin
            knee_ff[k] <= (k == 1) ? KNEE1_RESET : '0;
         end
         knee_count_ff <= KNEE_CNT_W'(2);
         pedestal_ff   <= '0;
         out_bits_ff   <= BITS_W'(32);
      end else if (csr_we) begin
         if (csr_index < CSR_IDX_W'(NUM_KNEES)) begin
            knee_ff[csr_index[KIDX_W-1:0]] <= csr_wdata;
         end else begin
            unique case (csr_reg_type'(csr_index))
               REG_KNEE_COUNT:  knee_count_ff <= csr_wdata[KNEE_CNT_W-1:0];
               REG_PEDESTAL:    pedestal_ff   <= csr_wdata[OUT_W-1:0];
               REG_OUTPUT_BITS: out_bits_ff   <= csr_wdata[BITS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Stage 1: classify the pixel and pick the last covering segment.
   always_comb begin
      for (int k = 0; k < NUM_KNEES; k++) begin
         kin[k]  = knee_ff[k][KNEE_IN_W-1:0];
         kout[k] = knee_ff[k][KNEE_W-1:KNEE_OUT_LSB];
      end
      x_w = PIX_W'(req_tdata[IN_BITS-1:0]);

      used_n = knee_count_ff;
      if (used_n < KNEE_CNT_W'(2)) begin
         used_n = KNEE_CNT_W'(2);
      end
      if (used_n > KNEE_CNT_W'(NUM_KNEES)) begin
         used_n = KNEE_CNT_W'(NUM_KNEES);
      end
      last_idx = used_n - KNEE_CNT_W'(1);

      last_in   = '0;
      last_kout = '0;
      for (int k = 0; k < NUM_KNEES; k++) begin
         if (KNEE_CNT_W'(k) == last_idx) begin
            last_in   = kin[k];
            last_kout = kout[k];
         end
      end

      seg_found = 1'b0;
      seg_s     = '0;
      seg_e     = '0;
      seg_so    = '0;
      seg_eo    = '0;
      for (int i = 0; i < NUM_KNEES - 1; i++) begin
         if (KNEE_CNT_W'(i) < last_idx && kin[i] < kin[i+1] &&
             x_w >= kin[i] && x_w <= kin[i+1]) begin
            seg_found = 1'b1;
            seg_s     = kin[i];
            seg_e     = kin[i+1];
            seg_so    = kout[i];
            seg_eo    = kout[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_tvalid;
         s1_beyond_ff <= x_w > last_in;
         s1_hit_ff    <= x_w == last_in;
         s1_found_ff  <= seg_found;
         s1_x_ff      <= req_tdata[IN_BITS-1:0];
         s1_s_ff      <= seg_s;
         s1_e_ff      <= seg_e;
         s1_so_ff     <= seg_so;
         s1_eo_ff     <= seg_eo;
         s1_lout_ff   <= last_kout;
      end
   end

   // Stage 2: segment deltas and base value.
   always_comb begin
      s2_neg_in = s1_eo_ff < s1_so_ff;
      s2_mag_in = s2_neg_in ? (s1_so_ff - s1_eo_ff) : (s1_eo_ff - s1_so_ff);
      s2_dx_in  = PIX_W'(s1_x_ff) - s1_s_ff;
      s2_d_in   = s1_e_ff - s1_s_ff;
      if (s1_beyond_ff) begin
         s2_base_in = '0;
      end else if (s1_hit_ff) begin
         s2_base_in = s1_lout_ff;
      end else if (s1_found_ff) begin
         s2_base_in = s1_so_ff;
      end else begin
         s2_base_in = '0;
      end
      if (s1_beyond_ff || s1_hit_ff || !s1_found_ff) begin
         s2_neg_in = 1'b0;
         s2_mag_in = '0;
         s2_dx_in  = '0;
         s2_d_in   = PIX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= s1_valid_ff;
         s2_beyond_ff <= s1_beyond_ff;
         s2_neg_ff    <= s2_neg_in;
         s2_base_ff   <= s2_base_in;
         s2_dx_ff     <= s2_dx_in;
         s2_d_ff      <= s2_d_in;
         s2_mag_ff    <= s2_mag_in;
      end
   end

   // Stage 3: product of input offset and output span.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff  <= s2_valid_ff;
         s3_beyond_ff <= s2_beyond_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_base_ff   <= s2_base_ff;
         s3_d_ff      <= s2_d_ff;
         s3_prod_ff   <= PROD_W'(s2_dx_ff) * PROD_W'(s2_mag_ff);
      end
   end

   // Divider: the product is below den * 2^32, so the top bits start as a
   // remainder already under the divisor.
   always_comb begin : div_step
      div_type              cur;
      logic [PIX_W:0]       t;
      logic                 qb;
      div_src[0].valid  = s3_valid_ff;
      div_src[0].beyond = s3_beyond_ff;
      div_src[0].neg    = s3_neg_ff;
      div_src[0].base   = s3_base_ff;
      div_src[0].den    = s3_d_ff;
      div_src[0].rem    = s3_prod_ff[PROD_W-1:OUT_W];
      div_src[0].quo    = s3_prod_ff[OUT_W-1:0];
      for (int j = 1; j < DIV_STAGES; j++) begin
         div_src[j] = dv_ff[j-1];
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
         cur = div_src[j];
         for (int b = 0; b < DIV_BITS; b++) begin
            t = {cur.rem, cur.quo[OUT_W-1]};
            if (t >= {1'b0, cur.den}) begin
               cur.rem = PIX_W'(t - {1'b0, cur.den});
               qb      = 1'b1;
            end else begin
               cur.rem = t[PIX_W-1:0];
               qb      = 1'b0;
            end
            cur.quo = {cur.quo[OUT_W-2:0], qb};
         end
         dv_in[j] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            dv_ff[j].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Stage 4: apply the floored quotient to the base.
   always_comb begin
      if (dv_ff[DIV_STAGES-1].neg) begin
         s4_curve_in = dv_ff[DIV_STAGES-1].base - dv_ff[DIV_STAGES-1].quo
                       - OUT_W'(|dv_ff[DIV_STAGES-1].rem);
      end else begin
         s4_curve_in = dv_ff[DIV_STAGES-1].base + dv_ff[DIV_STAGES-1].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff  <= dv_ff[DIV_STAGES-1].valid;
         s4_beyond_ff <= dv_ff[DIV_STAGES-1].beyond;
         s4_curve_ff  <= s4_curve_in;
      end
   end

   // Output stage: pedestal removal and clip.
   always_comb begin
      if (out_bits_ff >= BITS_W'(OUT_W)) begin
         bits_eff = BITS_W'(OUT_W);
      end else if (out_bits_ff == '0) begin
         bits_eff = BITS_W'(1);
      end else begin
         bits_eff = out_bits_ff;
      end
      one_sh    = (OUT_W+1)'(1) << bits_eff;
      clip_mask = one_sh[OUT_W-1:0] - OUT_W'(1);
      ped_sub   = (s4_curve_ff > pedestal_ff) ? (s4_curve_ff - pedestal_ff) : '0;
      rsp_tdata_in = (ped_sub > clip_mask) ? clip_mask : ped_sub;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= s4_valid_ff;
         rsp_tdata_ff  <= rsp_tdata_in;
         rsp_tuser_ff  <= s4_beyond_ff;
      end
   end

   always_comb begin
      rem_ok = 1'b1;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (dv_ff[j].valid && !(dv_ff[j].rem < dv_ff[j].den)) begin
            rem_ok = 1'b0;
         end
      end
   end

   a_beyond_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("beyond-curve beat carries a nonzero pixel");

   a_beyond_curve_zero: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && s4_beyond_ff |-> s4_curve_ff == '0)
      else $error("beyond-curve item has a nonzero curve value");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_d_ff != '0)
      else $error("zero divisor entered the divider");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ok)
      else $error("divider remainder not below divisor");

endmodule

// ----- tb/sv/decompand_checker.sv -----
`timescale 1ns / 1ps

module decompand_checker
   import pld_pkg::*;
#(
   parameter int NUM_KNEES = 5,
   parameter int IN_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [15:0] pixel_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_W-1:0]      rsp_tdata,   // [31:0] pixel_out
   input  logic [0:0]            rsp_tuser,   // [0] beyond_curve
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int KNEE_REGS = 5;

   typedef struct packed {
      logic [OUT_W-1:0] pixel_out;
      logic             beyond_curve;
   } linear_pixel_type;

   logic [KNEE_W-1:0]     knee_q [KNEE_REGS];
   logic [KNEE_CNT_W-1:0] knee_count_q;
   logic [OUT_W-1:0]      pedestal_q;
   logic [BITS_W-1:0]     out_bits_q;
   linear_pixel_type      expected_pixels [$];
   int                    checked_beats;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch at result beat %0d: %s", $realtime, checked_beats, msg);
      fail_count++;
   endtask

   function automatic linear_pixel_type decompand(input logic [PIX_W-1:0] pix);
      linear_pixel_type res;
      int     used;
      int     last;
      int     seg;
      bit     hit;
      longint x;
      longint s;
      longint e;
      longint so;
      longint eo;
      longint num;
      longint den;
      longint quo;
      longint curve;
      longint ped;
      longint v;
      longint bits;
      longint maxv;
      used = knee_count_q;
      if (used > NUM_KNEES) used = NUM_KNEES;
      if (used > KNEE_REGS) used = KNEE_REGS;
      if (used < 2) used = 2;
      last = used - 1;
      x = pix & ((longint'(1) << IN_BITS) - 1);
      curve = 0;
      hit = 1'b0;
      res.beyond_curve = 1'b0;
      e = knee_q[last][KNEE_IN_W-1:0];
      if (x > e) begin
         res.beyond_curve = 1'b1;
      end else if (x == e) begin
         curve = knee_q[last][KNEE_W-1:KNEE_OUT_LSB];
      end else begin
         for (seg = last - 1; seg >= 0; seg--) begin
            s  = knee_q[seg][KNEE_IN_W-1:0];
            e  = knee_q[seg+1][KNEE_IN_W-1:0];
            so = knee_q[seg][KNEE_W-1:KNEE_OUT_LSB];
            eo = knee_q[seg+1][KNEE_W-1:KNEE_OUT_LSB];
            if (!hit && s < e && x >= s && x <= e) begin
               num = (x - s) * (eo - so);
               den = e - s;
               if (num >= 0) quo = num / den;
               else quo = -((-num + den - 1) / den);
               curve = so + quo;
               hit = 1'b1;
            end
         end
      end
      ped = pedestal_q;
      v = (curve > ped) ? curve - ped : 0;
      bits = out_bits_q;
      if (bits < 1) bits = 1;
      maxv = (bits >= OUT_W) ? 64'hFFFF_FFFF : (longint'(1) << bits) - 1;
      if (v > maxv) v = maxv;
      res.pixel_out = v[OUT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      linear_pixel_type want;
      if (reset) begin
         foreach (knee_q[i]) knee_q[i] = '0;
         knee_q[1]    = KNEE1_RESET;
         knee_count_q = KNEE_CNT_W'(2);
         pedestal_q   = '0;
         out_bits_q   = BITS_W'(OUT_W);
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel_out %0h", rsp_tdata));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pixel_out)
                  report_mismatch($sformatf("pixel_out got %0h expected %0h",
                                            rsp_tdata, want.pixel_out));
               if (rsp_tuser[0] !== want.beyond_curve)
                  report_mismatch($sformatf("beyond_curve got %0b expected %0b",
                                            rsp_tuser[0], want.beyond_curve));
            end
            checked_beats++;
         end
         if (req_tvalid && req_tready) expected_pixels.push_back(decompand(req_tdata));
         if (csr_we) begin
            unique case (csr_reg_type'(csr_index))
               REG_KNEE0, REG_KNEE1, REG_KNEE2, REG_KNEE3, REG_KNEE4:
                  knee_q[csr_index] = csr_wdata[KNEE_W-1:0];
               REG_KNEE_COUNT:  knee_count_q = csr_wdata[KNEE_CNT_W-1:0];
               REG_PEDESTAL:    pedestal_q   = csr_wdata[OUT_W-1:0];
               REG_OUTPUT_BITS: out_bits_q   = csr_wdata[BITS_W-1:0];
            endcase
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ----- tb/sv/tb_piecewise_linear_decompander_core.sv -----
`timescale 1ns / 1ps

module tb_piecewise_linear_decompander_core
   import pld_pkg::*;
();

   localparam int KNEE_REGS     = 5;
   localparam int RESET_CYCLES  = 3;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 115;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_W-1:0]      rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    pending_count;
   int                    idle_cycles = 0;
   bit                    rx_steady = 1'b0;
   bit                    tx_steady = 1'b0;
   bit                    hold_request = 1'b0;
   logic [KNEE_IN_W-1:0]  knee_in_wr [KNEE_REGS];

   piecewise_linear_decompander_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   decompand_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (rx_steady || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(negedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= PIX_W'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= CSR_DATA_W'({$urandom, $urandom});
      @(negedge clock);
   endtask

   task automatic load_curve(input logic [CSR_DATA_W-1:0] kn [KNEE_REGS], input int count,
                             input logic [OUT_W-1:0] ped, input int bits);
      for (int i = 0; i < KNEE_REGS; i++) begin
         write_csr(csr_reg_type'(REG_KNEE0 + i), kn[i]);
         knee_in_wr[i] = kn[i][KNEE_IN_W-1:0];
      end
      write_csr(REG_KNEE_COUNT, CSR_DATA_W'(count));
      write_csr(REG_PEDESTAL, CSR_DATA_W'(ped));
      write_csr(REG_OUTPUT_BITS, CSR_DATA_W'(bits));
   endtask

   task automatic random_curve(input int phase);
      logic [CSR_DATA_W-1:0] kn [KNEE_REGS];
      logic [OUT_W-1:0]      outv;
      logic [OUT_W-1:0]      ped;
      logic [KNEE_IN_W-1:0]  inv;
      int                    pos;
      int                    shuffled;
      int                    count;
      int                    bits;
      pos = $urandom_range(0, 3000);
      shuffled = ($urandom_range(0, 9) == 0);
      outv = $urandom_range(0, 4096);
      for (int i = 0; i < KNEE_REGS; i++) begin
         if (shuffled) begin
            inv = KNEE_IN_W'($urandom);
         end else begin
            inv = KNEE_IN_W'(pos);
            if ($urandom_range(0, 5) != 0) pos += $urandom_range(1, 25000);
            if (pos > 65535) pos = 65535;
         end
         case ($urandom_range(0, 3))
            0: outv = $urandom;
            1: outv = $urandom_range(0, 1023);
            2: outv = 32'hFFFF_FFFF;
            default: outv = outv + $urandom_range(0, 1 << 20);
         endcase
         kn[i] = {outv, inv};
      end
      count = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 5) : $urandom_range(0, 7);
      case ($urandom_range(0, 3))
         0: ped = '0;
         1: ped = $urandom_range(0, 255);
         2: ped = $urandom >> 8;
         default: ped = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      endcase
      case ($urandom_range(0, 3))
         0: bits = 32;
         1: bits = $urandom_range(1, 31);
         2: bits = $urandom_range(0, 63);
         default: bits = $urandom_range(16, 32);
      endcase
      if (phase == 1) begin
         bits = 1;
         ped  = '0;
      end
      if (phase == 2) begin
         kn[KNEE_REGS-1] = '1;
         count = 5;
         bits  = 63;
      end
      if (phase == 6) begin
         ped  = 32'hFFFF_FFFF;
         bits = 0;
      end
      if (phase == 7) begin
         kn[0] = '0;
         bits  = 32;
      end
      load_curve(kn, count, ped, bits);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return PIX_W'($urandom);
      if (r < 8)
         return PIX_W'(knee_in_wr[$urandom_range(0, KNEE_REGS - 1)] +
                       $urandom_range(0, 6) - 3);
      if (r == 8) return $urandom_range(0, 1) ? '1 : '0;
      return PIX_W'($urandom_range(0, knee_in_wr[$urandom_range(0, KNEE_REGS - 1)]));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] curve_knees [KNEE_REGS];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_KNEE0;
      csr_wdata  = '0;
      knee_in_wr = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default curve is the identity
      send_pixel(16'd0);
      send_pixel(16'd1);
      send_pixel(16'h8000);
      send_pixel(16'hFFFF);
      drain();

      // zero-width first segment, falling segment, clip to 20 bits
      curve_knees = '{{32'd1000, 16'd100}, {32'd5000, 16'd100}, {32'd200, 16'd1000},
                      {32'd40000, 16'd3000}, {32'hFFFF_FFFF, 16'd60000}};
      load_curve(curve_knees, 5, 32'd150, 20);
      send_pixel(16'd0);
      send_pixel(16'd99);
      send_pixel(16'd100);
      send_pixel(16'd500);
      send_pixel(16'd999);
      send_pixel(16'd1000);
      send_pixel(16'd2000);
      send_pixel(16'd59999);
      send_pixel(16'd60000);
      send_pixel(16'd60001);
      send_pixel(16'hFFFF);
      drain();

      // reversed segment leaves a gap; count and width below range
      curve_knees = '{{32'd10, 16'd1000}, {32'd77, 16'd100}, 48'd0, 48'd0, 48'd0};
      load_curve(curve_knees, 1, 32'd0, 0);
      send_pixel(16'd50);
      send_pixel(16'd100);
      send_pixel(16'd101);
      send_pixel(16'hFFFF);
      drain();

      // count and width above range, pedestal at full scale
      curve_knees = '{{32'd1000, 16'd100}, {32'd5000, 16'd100}, {32'd200, 16'd1000},
                      {32'd40000, 16'd3000}, {32'hFFFF_FFFF, 16'd60000}};
      load_curve(curve_knees, 6, 32'hFFFF_FFFF, 33);
      send_pixel(16'd60000);
      send_pixel(16'd3000);
      drain();
      load_curve(curve_knees, 7, 32'd0, 63);
      send_pixel(16'd60000);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_curve(phase);
         tx_steady = (phase == 3 || phase == 4);
         rx_steady = (phase == 5);
         hold_request = (phase == 3);
         repeat (PHASE_ITEMS) send_pixel(pick_pixel());
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
